// ===== hdl/qple_pkg.sv =====
// Shared types, character codes and helpers for the quoted-printable line encoder.
package qple_pkg;

   localparam int MaxResults = 6;

   typedef enum logic [1:0] {
      KIND_CHAR     = 2'd0,
      KIND_BREAK    = 2'd1,
      KIND_BAD_CHAR = 2'd2,
      KIND_BAD_CRLF = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_Q_MODE           = 2'd0,
      CSR_FIRST_LINE_LIMIT = 2'd1,
      CSR_LINE_LIMIT       = 2'd2
   } csr_index_type;

   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_THREE      = 8'h33;
   localparam logic [7:0] CH_EQ         = 8'h3D;
   localparam logic [7:0] CH_QMARK      = 8'h3F;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_F    = 8'h66;
   localparam logic [7:0] CH_TILDE      = 8'h7E;

   localparam logic [10:0] LEN_MAX = 11'd2047;

   localparam logic [9:0] LIMIT_RESET = 10'd76;

   // One accepted byte's worth of results, queued between front and back.
   typedef struct packed {
      logic [2:0]                       count;
      logic                             done;
      kind_type [MaxResults-1:0]        kinds;
      logic [MaxResults-1:0][7:0]       chars;
   } plan_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         hex_digit = 8'h30 + {4'd0, nib};
      end else begin
         hex_digit = 8'h37 + {4'd0, nib};
      end
   endfunction

endpackage

// ===== hdl/qple_req_if.sv =====
// Input channel: one text byte per transfer.
interface qple_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== hdl/qple_rsp_if.sv =====
// Result channel: one encoded character or marker per transfer.
interface qple_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_char;
   logic       run_last;
   logic       text_done;

   modport source (output valid, output out_kind, output out_char, output run_last,
                   output text_done, input ready);
   modport sink (input valid, input out_kind, input out_char, input run_last,
                 input text_done, output ready);
endinterface

// ===== hdl/qple_front.sv =====
// Front end: accepts bytes, tracks line state and builds the result list per byte.
module qple_front (
   input  logic                 clock,
   input  logic                 reset,
   qple_req_if.sink             req_bus,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_wdata,
   input  logic                 queue_full,
   output logic                 push,
   output qple_pkg::plan_type   plan
);
   import qple_pkg::*;

   logic        q_mode_ff;
   logic [9:0]  first_limit_ff;
   logic [9:0]  line_limit_ff;

   logic [10:0] len_ff, len_in;
   logic        first_ff, first_in;
   logic        crp_ff, crp_in;
   logic        err_ff, err_in;

   plan_type    plan_c;
   logic        accept;

   function automatic logic reached(input logic [10:0] len, input logic [9:0] lim,
                                    input logic [2:0] k);
      reached = ({2'd0, lim} >= {9'd0, k}) &&
                (({1'b0, len} + {9'd0, k}) >= {2'd0, lim});
   endfunction

   function automatic logic [10:0] sat_add(input logic [10:0] len, input logic [1:0] k);
      logic [11:0] sum;
      sum = {1'b0, len} + {10'd0, k};
      if (sum > {1'b0, LEN_MAX}) begin
         sat_add = LEN_MAX;
      end else begin
         sat_add = sum[10:0];
      end
   endfunction

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;
   assign push          = accept && (plan_c.count != 3'd0);
   assign plan          = plan_c;

   always_comb begin
      logic [7:0] b;
      logic       q;
      logic       eot;
      logic [9:0] lim;
      logic [2:0] cnt;
      logic       r2, r3, r4, r5;
      kind_type   err;
      logic       has_err;

      b   = req_bus.text_byte;
      eot = req_bus.end_of_text;
      q   = q_mode_ff;
      lim = first_ff ? first_limit_ff : line_limit_ff;
      r2  = reached(len_ff, lim, 3'd2);
      r3  = reached(len_ff, lim, 3'd3);
      r4  = reached(len_ff, lim, 3'd4);
      r5  = reached(len_ff, lim, 3'd5);

      plan_c       = '0;
      cnt          = 3'd0;
      err          = KIND_BAD_CRLF;
      has_err      = 1'b0;
      len_in       = len_ff;
      first_in     = first_ff;
      crp_in       = 1'b0;
      err_in       = err_ff;

      if (err_ff) begin
         // discard until end of text
         if (eot) begin
            len_in   = '0;
            first_in = 1'b1;
            err_in   = 1'b0;
         end
      end else begin
         if (crp_ff) begin
            if (b == CH_LF) begin
               plan_c.kinds[cnt] = KIND_BREAK; cnt = cnt + 3'd1;
               len_in   = '0;
               first_in = 1'b0;
            end else begin
               has_err = 1'b1;
               err     = KIND_BAD_CRLF;
            end
         end else if (b >= CH_BANG && b <= CH_TILDE && b != CH_EQ && b != CH_QMARK) begin
            if (r3) begin
               if (q) begin
                  plan_c.chars[cnt] = b; cnt = cnt + 3'd1;
                  plan_c.kinds[cnt] = KIND_BREAK; cnt = cnt + 3'd1;
                  len_in = '0;
               end else begin
                  plan_c.chars[cnt] = CH_EQ; cnt = cnt + 3'd1;
                  plan_c.kinds[cnt] = KIND_BREAK; cnt = cnt + 3'd1;
                  plan_c.chars[cnt] = b; cnt = cnt + 3'd1;
                  len_in = 11'd1;
               end
               first_in = 1'b0;
            end else begin
               plan_c.chars[cnt] = b; cnt = cnt + 3'd1;
               len_in = sat_add(len_ff, 2'd1);
            end
         end else if (b == CH_SPACE) begin
            if (q) begin
               plan_c.chars[cnt] = CH_UNDERSCORE; cnt = cnt + 3'd1;
               len_in = sat_add(len_ff, 2'd1);
            end else if (r4) begin
               plan_c.chars[cnt] = CH_SPACE; cnt = cnt + 3'd1;
               plan_c.chars[cnt] = CH_EQ; cnt = cnt + 3'd1;
               plan_c.kinds[cnt] = KIND_BREAK; cnt = cnt + 3'd1;
               len_in   = '0;
               first_in = 1'b0;
            end else if (r3) begin
               plan_c.chars[cnt] = CH_EQ; cnt = cnt + 3'd1;
               plan_c.kinds[cnt] = KIND_BREAK; cnt = cnt + 3'd1;
               plan_c.chars[cnt] = CH_SPACE; cnt = cnt + 3'd1;
               len_in   = 11'd1;
               first_in = 1'b0;
            end else begin
               plan_c.chars[cnt] = CH_SPACE; cnt = cnt + 3'd1;
               len_in = sat_add(len_ff, 2'd1);
            end
         end else if (b == CH_QMARK) begin
            if (q) begin
               if (r2) begin
                  plan_c.kinds[cnt] = KIND_BREAK; cnt = cnt + 3'd1;
                  first_in = 1'b0;
                  len_in   = 11'd3;
               end else begin
                  len_in = sat_add(len_ff, 2'd3);
               end
               plan_c.chars[cnt] = CH_EQ; cnt = cnt + 3'd1;
               plan_c.chars[cnt] = CH_THREE; cnt = cnt + 3'd1;
               plan_c.chars[cnt] = CH_LOWER_F; cnt = cnt + 3'd1;
            end else begin
               plan_c.chars[cnt] = CH_QMARK; cnt = cnt + 3'd1;
               len_in = sat_add(len_ff, 2'd1);
            end
         end else if (b == CH_CR) begin
            if (q) begin
               has_err = 1'b1;
               err     = KIND_BAD_CHAR;
            end else begin
               crp_in = 1'b1;
            end
         end else begin
            if (r5) begin
               if (!q) begin
                  plan_c.chars[cnt] = CH_EQ; cnt = cnt + 3'd1;
               end
               plan_c.kinds[cnt] = KIND_BREAK; cnt = cnt + 3'd1;
               first_in = 1'b0;
               len_in   = 11'd3;
            end else begin
               len_in = sat_add(len_ff, 2'd3);
            end
            plan_c.chars[cnt] = CH_EQ; cnt = cnt + 3'd1;
            plan_c.chars[cnt] = hex_digit(b[7:4]); cnt = cnt + 3'd1;
            plan_c.chars[cnt] = hex_digit(b[3:0]); cnt = cnt + 3'd1;
         end

         // a CR as the last byte has no LF to pair with
         if (!has_err && eot && crp_in) begin
            has_err = 1'b1;
            err     = KIND_BAD_CRLF;
         end

         if (has_err) begin
            plan_c.kinds[cnt] = err; cnt = cnt + 3'd1;
            plan_c.done = 1'b1;
            crp_in = 1'b0;
            if (eot) begin
               len_in   = '0;
               first_in = 1'b1;
            end else begin
               err_in = 1'b1;
            end
         end else if (eot) begin
            if (len_in != 11'd0) begin
               plan_c.kinds[cnt] = KIND_BREAK; cnt = cnt + 3'd1;
            end
            plan_c.done = 1'b1;
            len_in   = '0;
            first_in = 1'b1;
            crp_in   = 1'b0;
         end
      end
      plan_c.count = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_mode_ff      <= 1'b0;
         first_limit_ff <= LIMIT_RESET;
         line_limit_ff  <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_Q_MODE:           q_mode_ff      <= csr_wdata[0];
            CSR_FIRST_LINE_LIMIT: first_limit_ff <= csr_wdata;
            CSR_LINE_LIMIT:       line_limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         first_ff <= 1'b1;
         crp_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         len_ff   <= len_in;
         first_ff <= first_in;
         crp_ff   <= crp_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== hdl/qple_queue.sv =====
// Two-entry queue of per-byte result lists between front and back.
module qple_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qple_pkg::plan_type   push_plan,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output qple_pkg::plan_type   head
);
   import qple_pkg::*;

   plan_type    slot_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

endmodule

// ===== hdl/qple_back.sv =====
// Back end: walks the head result list and hands out one result per transfer.
module qple_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  qple_pkg::plan_type   head,
   output logic                 pop,
   qple_rsp_if.source           rsp_bus
);
   import qple_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       last;
   logic       xfer;

   assign last = (idx_ff == head.count - 3'd1);
   assign xfer = rsp_bus.valid && rsp_bus.ready;
   assign pop  = xfer && last;

   assign rsp_bus.valid     = !empty;
   assign rsp_bus.out_kind  = head.kinds[idx_ff];
   assign rsp_bus.out_char  = (head.kinds[idx_ff] == KIND_CHAR) ? head.chars[idx_ff] : 8'd0;
   assign rsp_bus.run_last  = last;
   assign rsp_bus.text_done = last && head.done;

   always_comb begin
      idx_in = idx_ff;
      if (xfer) begin
         idx_in = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== hdl/quoted_printable_line_encoder.sv =====
// Quoted-printable line encoder top level: front end, result queue and back end.
// Each byte's result list is registered in the queue and offered once it is at the head.
// The back end hands out one result per cycle while rsp_bus.ready is held high; the
// front end takes a new byte while the queue is not full, and result-free bytes skip it.
// Reset (synchronous, active high) clears line state, empties the queue and restores
// q_mode 0 and both line limits to 76.
module quoted_printable_line_encoder (
   input  logic        clock,
   input  logic        reset,
   qple_req_if.sink    req_bus,
   qple_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   import qple_pkg::*;

   plan_type push_plan;
   plan_type head;
   logic     push;
   logic     pop;
   logic     full;
   logic     empty;

   qple_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (full),
      .push       (push),
      .plan       (push_plan)
   );

   qple_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_plan (push_plan),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   qple_back u_back (
      .clock   (clock),
      .reset   (reset),
      .empty   (empty),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the quoted-printable line encoder.
module tb;
   import qple_pkg::*;

   typedef struct {
      kind_type   kind;
      logic [7:0] ch;
      logic       run_last;
      logic       text_done;
   } symbol_type;

   typedef logic [7:0] text_type[$];

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [9:0] csr_wdata;

   qple_req_if req_bus();
   qple_rsp_if rsp_bus();

   quoted_printable_line_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // encoder state as the testbench tracks it
   logic cfg_q_mode;
   int   cfg_first_limit;
   int   cfg_line_limit;
   int   cur_len;
   logic first_line;
   logic cr_wait;
   logic text_failed;

   symbol_type step_symbols[$];
   symbol_type awaited_symbols[$];

   int sender_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int mismatch_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void clear_text_state();
      cur_len = 0;
      first_line = 1'b1;
      cr_wait = 1'b0;
      text_failed = 1'b0;
   endfunction

   function automatic void put_symbol(input kind_type kind, input logic [7:0] ch);
      symbol_type s;
      s.kind = kind;
      s.ch = (kind == KIND_CHAR) ? ch : 8'h00;
      s.run_last = 1'b0;
      s.text_done = 1'b0;
      step_symbols.insert(step_symbols.size(), s);
   endfunction

   function automatic void put_break();
      put_symbol(KIND_BREAK, 8'h00);
      cur_len = 0;
      first_line = 1'b0;
   endfunction

   function automatic void grow(input int k);
      cur_len = (cur_len + k > int'(LEN_MAX)) ? int'(LEN_MAX) : cur_len + k;
   endfunction

   // limits below k never reach the threshold
   function automatic bit near_limit(input int k);
      int lim;
      lim = first_line ? cfg_first_limit : cfg_line_limit;
      return lim >= k && cur_len >= lim - k;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h37 + {4'd0, nib};
   endfunction

   function automatic void encode_byte(input logic [7:0] b, input logic eot);
      logic     faulted;
      kind_type fault_kind;
      int       tail;
      step_symbols.delete();
      faulted = 1'b0;
      fault_kind = KIND_BAD_CRLF;
      if (text_failed) begin
         if (eot) clear_text_state();
         return;
      end
      if (cr_wait) begin
         cr_wait = 1'b0;
         if (b == CH_LF) put_break();
         else faulted = 1'b1;
      end else if (b >= CH_BANG && b <= CH_TILDE && b != CH_EQ && b != CH_QMARK) begin
         if (near_limit(3)) begin
            if (cfg_q_mode) begin
               put_symbol(KIND_CHAR, b);
               put_break();
            end else begin
               put_symbol(KIND_CHAR, CH_EQ);
               put_break();
               put_symbol(KIND_CHAR, b);
               grow(1);
            end
         end else begin
            put_symbol(KIND_CHAR, b);
            grow(1);
         end
      end else if (b == CH_SPACE) begin
         if (cfg_q_mode) begin
            put_symbol(KIND_CHAR, CH_UNDERSCORE);
            grow(1);
         end else if (near_limit(4)) begin
            put_symbol(KIND_CHAR, CH_SPACE);
            put_symbol(KIND_CHAR, CH_EQ);
            put_break();
         end else if (near_limit(3)) begin
            put_symbol(KIND_CHAR, CH_EQ);
            put_break();
            put_symbol(KIND_CHAR, CH_SPACE);
            grow(1);
         end else begin
            put_symbol(KIND_CHAR, CH_SPACE);
            grow(1);
         end
      end else if (b == CH_QMARK) begin
         if (cfg_q_mode) begin
            if (near_limit(2)) put_break();
            put_symbol(KIND_CHAR, CH_EQ);
            put_symbol(KIND_CHAR, CH_THREE);
            put_symbol(KIND_CHAR, CH_LOWER_F);
            grow(3);
         end else begin
            put_symbol(KIND_CHAR, CH_QMARK);
            grow(1);
         end
      end else if (b == CH_CR) begin
         if (cfg_q_mode) begin
            faulted = 1'b1;
            fault_kind = KIND_BAD_CHAR;
         end else begin
            cr_wait = 1'b1;
         end
      end else begin
         if (near_limit(5)) begin
            if (!cfg_q_mode) put_symbol(KIND_CHAR, CH_EQ);
            put_break();
         end
         put_symbol(KIND_CHAR, CH_EQ);
         put_symbol(KIND_CHAR, hex_char(b[7:4]));
         put_symbol(KIND_CHAR, hex_char(b[3:0]));
         grow(3);
      end

      // a CR on the last byte never gets its LF
      if (!faulted && eot && cr_wait) faulted = 1'b1;

      if (faulted) begin
         put_symbol(fault_kind, 8'h00);
         tail = step_symbols.size() - 1;
         step_symbols[tail].run_last = 1'b1;
         step_symbols[tail].text_done = 1'b1;
         if (eot) clear_text_state();
         else text_failed = 1'b1;
      end else begin
         if (eot) begin
            if (cur_len != 0) put_break();
            if (step_symbols.size() > 0) begin
               step_symbols[step_symbols.size() - 1].text_done = 1'b1;
            end
            clear_text_state();
         end
         if (step_symbols.size() > 0) begin
            step_symbols[step_symbols.size() - 1].run_last = 1'b1;
         end
      end
      foreach (step_symbols[i]) awaited_symbols.insert(awaited_symbols.size(), step_symbols[i]);
   endfunction

   // result side: random stalls, or a long hold-off when requested
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_symbols
      symbol_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_symbols.size() == 0) begin
            $error("unexpected transfer: out_kind %0d out_char 8'h%02h",
                   rsp_bus.out_kind, rsp_bus.out_char);
            mismatch_count++;
         end else begin
            want = awaited_symbols.pop_front();
            if (rsp_bus.out_kind !== want.kind) begin
               $error("out_kind: expected %0d, got %0d", want.kind, rsp_bus.out_kind);
               mismatch_count++;
            end
            if (rsp_bus.out_char !== want.ch) begin
               $error("out_char: expected 8'h%02h, got 8'h%02h", want.ch, rsp_bus.out_char);
               mismatch_count++;
            end
            if (rsp_bus.run_last !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_bus.run_last);
               mismatch_count++;
            end
            if (rsp_bus.text_done !== want.text_done) begin
               $error("text_done: expected %0b, got %0b", want.text_done, rsp_bus.text_done);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.text_byte <= b;
      req_bus.end_of_text <= eot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      encode_byte(b, eot);
      @(negedge clock);
   endtask

   task automatic send_text(input text_type txt);
      foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
   endtask

   // drain all results, then allow for bytes that produce none
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (awaited_symbols.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      settle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[9:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_Q_MODE:           cfg_q_mode = value[0];
         CSR_FIRST_LINE_LIMIT: cfg_first_limit = value;
         CSR_LINE_LIMIT:       cfg_line_limit = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input int q, input int first_limit, input int limit);
      write_csr(CSR_Q_MODE, q);
      write_csr(CSR_FIRST_LINE_LIMIT, first_limit);
      write_csr(CSR_LINE_LIMIT, limit);
   endtask

   function automatic logic [7:0] pick_byte();
      int         sel;
      logic [7:0] b;
      sel = $urandom_range(99);
      if (sel < 45) b = 8'($urandom_range(CH_BANG, CH_TILDE));
      else if (sel < 60) b = CH_SPACE;
      else if (sel < 66) b = CH_QMARK;
      else if (sel < 70) b = CH_EQ;
      else if (sel < 92) begin
         b = 8'($urandom_range(255));
         if (b == CH_CR) b = CH_LF;
      end else begin
         b = CH_CR;
      end
      // a CR kills a Q-mode text, so keep it rare there
      if (cfg_q_mode && b == CH_CR && $urandom_range(3) != 0) b = CH_SPACE;
      return b;
   endfunction

   // texts of random length; in body mode a CR is mostly followed by LF
   task automatic random_texts(input int budget);
      int         sent;
      int         len;
      logic       prev_cr;
      logic [7:0] b;
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 25);
         prev_cr = 1'b0;
         for (int i = 0; i < len; i++) begin
            if (prev_cr && $urandom_range(9) != 0) b = CH_LF;
            else b = pick_byte();
            if (!text_failed) sent++;
            send_byte(b, i == len - 1);
            prev_cr = (b == CH_CR);
         end
      end
   endtask

   task automatic test_defaults();
      text_type txt;
      sender_idle_pct = 25;
      stall_pct = 25;
      txt = '{"A", CH_SPACE, CH_QMARK, CH_EQ, 8'h00, 8'hFF, 8'h7F, CH_BANG, CH_TILDE,
              8'h09, CH_CR, CH_LF, 8'h80};
      send_text(txt);
   endtask

   task automatic test_soft_breaks();
      text_type txt;
      txt = '{"x", "x", "x", 8'h00, "x", CH_SPACE, "x", "x", "x", "x", "x", "q",
              CH_SPACE, CH_QMARK, "x", "x", "x", "x", CH_QMARK, CH_EQ, "x"};
      for (int q = 0; q < 2; q++) begin
         set_config(q, 8, 9);
         send_text(txt);
      end
   endtask

   task automatic test_first_line();
      text_type txt;
      text_type split;
      for (int i = 0; i < 16; i++) txt.insert(txt.size(), "y");
      for (int i = 0; i < 6; i++) split.insert(split.size(), "y");
      split.insert(split.size(), CH_CR);
      split.insert(split.size(), CH_LF);
      for (int i = 0; i < 10; i++) split.insert(split.size(), "y");
      set_config(0, 8, 1000);
      send_text(txt);
      set_config(1, 8, 1000);
      send_text(txt);
      set_config(0, 1000, 8);
      send_text(split);
   endtask

   task automatic test_line_ends();
      text_type txt;
      set_config(0, 76, 76);
      txt = '{"a", CH_CR, CH_LF, "b"};
      send_text(txt);
      txt = '{CH_CR, CH_LF};
      send_text(txt);
      // CR followed by something else: error, rest of the text ignored
      txt = '{"a", CH_CR, "b", "c", CH_SPACE};
      send_text(txt);
      txt = '{CH_CR};
      send_text(txt);
      txt = '{"a", CH_CR};
      send_text(txt);
      // the pending CR survives a mode change
      send_byte(CH_CR, 1'b0);
      write_csr(CSR_Q_MODE, 1);
      send_byte(CH_LF, 1'b1);
      txt = '{"a", CH_CR, "b", CH_QMARK};
      send_text(txt);
      txt = '{CH_CR};
      send_text(txt);
   endtask

   // Q-mode spaces never break, so the line runs well past its limit
   task automatic test_long_line();
      set_config(1, 8, 8);
      sender_idle_pct = 0;
      stall_pct = 0;
      repeat (30) send_byte(CH_SPACE, 1'b0);
      send_byte(8'h01, 1'b1);
   endtask

   task automatic test_backpressure();
      set_config(0, 1000, 1000);
      sender_idle_pct = 0;
      stall_pct = 10;
      hold_cycles = 300;
      for (int i = 0; i < 16; i++) send_byte(8'h80 + i[7:0], i == 15);
      // hold new transfers until the block has emptied
      settle();
   endtask

   task automatic test_random_texts();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_config(0, 8, 1000);
            1: set_config(1, 1000, 8);
            2: set_config(0, $urandom_range(8, 40), $urandom_range(8, 40));
            3: set_config($urandom_range(1), $urandom_range(8, 1000), $urandom_range(8, 60));
            default: set_config(1, $urandom_range(8, 30), $urandom_range(8, 30));
         endcase
         case (phase)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 72; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 72; end
            3: begin sender_idle_pct = 18; stall_pct = 18; end
            default: begin sender_idle_pct = 0; stall_pct = 72; end
         endcase
         random_texts(20);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_Q_MODE;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.text_byte = '0;
      req_bus.end_of_text = 1'b0;
      cfg_q_mode = 1'b0;
      cfg_first_limit = LIMIT_RESET;
      cfg_line_limit = LIMIT_RESET;
      clear_text_state();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_soft_breaks();
      test_first_line();
      test_line_ends();
      test_long_line();
      test_backpressure();
      test_random_texts();

      settle();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== quoted_printable_line_encoder.f =====
hdl/qple_pkg.sv
hdl/qple_req_if.sv
hdl/qple_rsp_if.sv
hdl/qple_front.sv
hdl/qple_queue.sv
hdl/qple_back.sv
hdl/quoted_printable_line_encoder.sv
tb/tb.sv
